// File: rtl/spcm_pkg.sv
// Shared types, constants, tables and arithmetic helpers of the stereo peak compressor.
package spcm_pkg;

  localparam int SampleBits  = 24;
  localparam int MagBits     = SampleBits - 1;
  localparam int LogDepth    = 64;
  localparam int LogBits     = $clog2(LogDepth);
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 17;
  localparam int TabBits     = 17;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [MagBits-1:0]           mag_t;

  typedef struct packed {
    sample_t wet_left;
    sample_t wet_right;
    sample_t dry_left;
    sample_t dry_right;
    mag_t    peak;
  } item_t;

  typedef struct packed {
    logic        comp_enable;
    logic [15:0] comp_slope;
    logic [13:0] makeup_gain;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [16:0] dry_wet;
    logic [15:0] output_gain;
  } cfg_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_COMP_ENABLE   = 3'd0,
    REG_COMP_SLOPE    = 3'd1,
    REG_MAKEUP_GAIN   = 3'd2,
    REG_ATTACK_COEFF  = 3'd3,
    REG_RELEASE_COEFF = 3'd4,
    REG_DRY_WET       = 3'd5,
    REG_OUTPUT_GAIN   = 3'd6
  } reg_idx_e;

  typedef logic [LogDepth:0][TabBits-1:0] tab_t;

  function automatic logic [15:0] log2_frac(input logic [63:0] w_in);
    logic [63:0] w;
    logic [15:0] r;
    w = w_in;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      w = (w * w) >> 30;
      r = {r[14:0], 1'b0};
      if (w >= 64'h8000_0000) begin
        w = w >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tab_t build_log();
    tab_t t;
    logic [63:0] w;
    t = '0;
    for (int i = 0; i < LogDepth; i++) begin
      w = 64'h4000_0000 + (((64'(i)) << 30) + 64'(LogDepth / 2)) / 64'(LogDepth);
      t[i] = {1'b0, log2_frac(w)};
    end
    t[LogDepth] = 17'h10000;
    return t;
  endfunction

  function automatic tab_t build_exp();
    tab_t t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [15:0] target;
    t = '0;
    t[0] = 17'h10000;
    for (int i = 1; i < LogDepth; i++) begin
      target = 16'((((64'(i)) << 16) + 64'(LogDepth / 2)) / 64'(LogDepth));
      lo = 64'h4000_0000;
      hi = 64'h7FFF_FFFF;
      for (int it = 0; it < 32; it++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (log2_frac(mid) >= target) hi = mid;
          else lo = mid + 64'd1;
        end
      end
      t[i] = 17'(div_u64((64'd1 << 46) + (lo >> 1), lo));
    end
    t[LogDepth] = 17'h08000;
    return t;
  endfunction

  localparam tab_t LogTab = build_log();
  localparam tab_t ExpTab = build_exp();

  function automatic logic [TabBits-1:0] interp(input tab_t tab, input logic [15:0] f);
    logic [LogBits-1:0] idx;
    logic [15:0]        r;
    logic [TabBits-1:0] a;
    logic [TabBits-1:0] b;
    logic [32:0]        d;
    idx = f[15 -: LogBits];
    r   = {f[15-LogBits:0], LogBits'(0)};
    a   = tab[idx];
    b   = tab[32'(idx) + 1];
    if (b >= a) begin
      d = 33'(b - a) * 33'(r);
      return a + TabBits'(d >> 16);
    end else begin
      d = 33'(a - b) * 33'(r);
      return a - TabBits'(d >> 16);
    end
  endfunction

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
    logic [63:0] mag;
    logic [63:0] half;
    half = 64'd1 << (s - 1);
    if (!v[63]) begin
      return signed'((64'(v) + half) >> s);
    end else begin
      mag = 64'(-v);
      return -signed'((mag + half) >> s);
    end
  endfunction

endpackage

// File: rtl/stereo_peak_compressor_mix.sv
// Top level: stereo peak compressor with dry/wet mix, configuration registers and queue.
// An input transaction passes the front register and the queue to the back-end sequencer.
// With compression on the sequencer runs envelope, log, slope, exp, makeup, wet, mix and
// output steps; with it off only the wet, mix and output steps. It takes a new frame from
// the queue only after the last one has left the output step, which waits out a stall.
// Reset clears the envelope, the registers to their defaults, the queue and all valids.
module stereo_peak_compressor_mix (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [spcm_pkg::SampleBits-1:0] wet_left_i,
  input  logic signed [spcm_pkg::SampleBits-1:0] wet_right_i,
  input  logic signed [spcm_pkg::SampleBits-1:0] dry_left_i,
  input  logic signed [spcm_pkg::SampleBits-1:0] dry_right_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [spcm_pkg::SampleBits-1:0] out_left_o,
  output logic signed [spcm_pkg::SampleBits-1:0] out_right_o,
  output logic                                   clipped_o,
  input  logic                                   cfg_we_i,
  input  logic [spcm_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [spcm_pkg::CfgDataBits-1:0]       cfg_wdata_i
);

  spcm_pkg::cfg_t    cfg_q;
  spcm_pkg::item_t   push_item;
  spcm_pkg::item_t   pop_item;
  spcm_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comp_enable   <= 1'b0;
      cfg_q.comp_slope    <= 16'd0;
      cfg_q.makeup_gain   <= 14'd4096;
      cfg_q.attack_coeff  <= 16'd65263;
      cfg_q.release_coeff <= 16'd65522;
      cfg_q.dry_wet       <= 17'd65536;
      cfg_q.output_gain   <= 16'd4096;
    end else if (cfg_we_i) begin
      case (spcm_pkg::reg_idx_e'(cfg_idx_i))
        spcm_pkg::REG_COMP_ENABLE:   cfg_q.comp_enable   <= cfg_wdata_i[0];
        spcm_pkg::REG_COMP_SLOPE:    cfg_q.comp_slope    <= cfg_wdata_i[15:0];
        spcm_pkg::REG_MAKEUP_GAIN:   cfg_q.makeup_gain   <= cfg_wdata_i[13:0];
        spcm_pkg::REG_ATTACK_COEFF:  cfg_q.attack_coeff  <= cfg_wdata_i[15:0];
        spcm_pkg::REG_RELEASE_COEFF: cfg_q.release_coeff <= cfg_wdata_i[15:0];
        spcm_pkg::REG_DRY_WET:       cfg_q.dry_wet       <= cfg_wdata_i[16:0];
        spcm_pkg::REG_OUTPUT_GAIN:   cfg_q.output_gain   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  spcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .wet_left_i  (wet_left_i),
    .wet_right_i (wet_right_i),
    .dry_left_i  (dry_left_i),
    .dry_right_i (dry_right_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .item_o      (push_item)
  );

  spcm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .stat_o      (q_stat)
  );

  spcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_stat.empty),
    .q_data_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .clipped_o   (clipped_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("queue push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

// File: rtl/spcm_front.sv
// Front stage: input register and peak magnitude of the wet pair.
module spcm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spcm_pkg::sample_t wet_left_i,
  input  spcm_pkg::sample_t wet_right_i,
  input  spcm_pkg::sample_t dry_left_i,
  input  spcm_pkg::sample_t dry_right_i,
  input  logic              q_full_i,
  output logic              push_o,
  output spcm_pkg::item_t   item_o
);

  logic                     valid_q;
  logic                     valid_d;
  logic                     accept;
  spcm_pkg::item_t          item_q;
  spcm_pkg::mag_t           mag_l;
  spcm_pkg::mag_t           mag_r;

  function automatic spcm_pkg::mag_t mag_sat(input spcm_pkg::sample_t v);
    logic signed [spcm_pkg::SampleBits:0] ext;
    logic [spcm_pkg::SampleBits:0]        m;
    ext = (spcm_pkg::SampleBits + 1)'(v);
    m   = v[spcm_pkg::SampleBits-1] ? unsigned'(-ext) : unsigned'(ext);
    if (m > {2'b00, {spcm_pkg::MagBits{1'b1}}}) return {spcm_pkg::MagBits{1'b1}};
    return m[spcm_pkg::MagBits-1:0];
  endfunction

  assign mag_l      = mag_sat(wet_left_i);
  assign mag_r      = mag_sat(wet_right_i);
  assign in_stall_o = valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~q_full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (push_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.wet_left  <= wet_left_i;
      item_q.wet_right <= wet_right_i;
      item_q.dry_left  <= dry_left_i;
      item_q.dry_right <= dry_right_i;
      item_q.peak      <= (mag_l > mag_r) ? mag_l : mag_r;
    end
  end

endmodule

// File: rtl/spcm_queue.sv
// Two-entry queue between the front stage and the compressor back end.
module spcm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spcm_pkg::item_t   push_data_i,
  input  logic              pop_i,
  output spcm_pkg::item_t   pop_data_o,
  output spcm_pkg::q_stat_t stat_o
);

  spcm_pkg::item_t mem_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;
  logic [1:0]      count_d;

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.count = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    else if (pop_i && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/spcm_back.sv
// Back end: envelope, gain computer, wet scaling, mix, output gain and output register.
module spcm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spcm_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  spcm_pkg::item_t   q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spcm_pkg::sample_t out_left_o,
  output spcm_pkg::sample_t out_right_o,
  output logic              clipped_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_A,
    ST_ENV_B,
    ST_LOG,
    ST_SLOPE,
    ST_EXP,
    ST_MAKEUP,
    ST_WET,
    ST_MIX_A,
    ST_MIX_B,
    ST_OUT
  } state_e;

  localparam logic [22:0] Thresh = 23'h040000;
  localparam logic signed [63:0] SatHi = 64'sd8388607;
  localparam logic signed [63:0] SatLo = -64'sd8388608;

  state_e                   state_q;
  spcm_pkg::item_t          item_q;
  logic [22:0]              env_q;
  logic [15:0]              c_q;
  logic [39:0]              acc_q;
  logic                     bypass_q;
  logic [18:0]              l_q;
  logic [18:0]              s_q;
  logic [16:0]              gain_q;
  logic [18:0]              g2_q;
  logic signed [27:0]       wet_l_q;
  logic signed [27:0]       wet_r_q;
  logic signed [49:0]       macc_l_q;
  logic signed [49:0]       macc_r_q;
  logic signed [33:0]       mr_l_q;
  logic signed [33:0]       mr_r_q;
  logic                     out_valid_q;
  spcm_pkg::sample_t        out_left_q;
  spcm_pkg::sample_t        out_right_q;
  logic                     clipped_q;

  logic [15:0]              c_sel;
  logic [22:0]              env_next;
  logic [2:0]               p_off;
  logic [15:0]              frac;
  logic [18:0]              l_next;
  logic [18:0]              s_next;
  logic [16:0]              gain_next;
  logic [18:0]              g2_next;
  logic signed [27:0]       wet_l_next;
  logic signed [27:0]       wet_r_next;
  logic [16:0]              dw;
  logic signed [63:0]       o_l;
  logic signed [63:0]       o_r;
  logic                     out_free;

  assign pop_o       = (state_q == ST_IDLE) && !q_empty_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;
  assign clipped_o   = clipped_q;

  always_comb begin
    c_sel    = (item_q.peak > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
    env_next = 23'((acc_q + 40'(17'h10000 - 17'(c_q)) * 40'(item_q.peak) + 40'd32768) >> 16);

    if (env_q[22]) begin
      p_off = 3'd4;
      frac  = env_q[21:6];
    end else if (env_q[21]) begin
      p_off = 3'd3;
      frac  = env_q[20:5];
    end else if (env_q[20]) begin
      p_off = 3'd2;
      frac  = env_q[19:4];
    end else if (env_q[19]) begin
      p_off = 3'd1;
      frac  = env_q[18:3];
    end else begin
      p_off = 3'd0;
      frac  = env_q[17:2];
    end
    l_next = {p_off, 16'd0} + 19'(spcm_pkg::interp(spcm_pkg::LogTab, frac));

    s_next    = 19'((35'(cfg_i.comp_slope) * 35'(l_q)) >> 16);
    gain_next = bypass_q ? 17'h10000
                         : (spcm_pkg::interp(spcm_pkg::ExpTab, s_q[15:0]) >> s_q[18:16]);
    g2_next   = 19'((31'(gain_q) * 31'(cfg_i.makeup_gain) + 31'd2048) >> 12);

    if (cfg_i.comp_enable) begin
      wet_l_next = 28'(spcm_pkg::rnd_shift(64'(item_q.wet_left) * signed'(64'(g2_q)), 16));
      wet_r_next = 28'(spcm_pkg::rnd_shift(64'(item_q.wet_right) * signed'(64'(g2_q)), 16));
    end else begin
      wet_l_next = 28'(item_q.wet_left);
      wet_r_next = 28'(item_q.wet_right);
    end

    dw = (cfg_i.dry_wet > 17'h10000) ? 17'h10000 : cfg_i.dry_wet;

    o_l = spcm_pkg::rnd_shift(64'(mr_l_q) * signed'(64'(cfg_i.output_gain)), 12);
    o_r = spcm_pkg::rnd_shift(64'(mr_r_q) * signed'(64'(cfg_i.output_gain)), 12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            item_q  <= q_data_i;
            state_q <= cfg_i.comp_enable ? ST_ENV_A : ST_WET;
          end
        end
        ST_ENV_A: begin
          c_q     <= c_sel;
          acc_q   <= 40'(c_sel) * 40'(env_q);
          state_q <= ST_ENV_B;
        end
        ST_ENV_B: begin
          env_q   <= env_next;
          state_q <= ST_LOG;
        end
        ST_LOG: begin
          bypass_q <= (env_q <= Thresh);
          l_q      <= l_next;
          state_q  <= ST_SLOPE;
        end
        ST_SLOPE: begin
          s_q     <= s_next;
          state_q <= ST_EXP;
        end
        ST_EXP: begin
          gain_q  <= gain_next;
          state_q <= ST_MAKEUP;
        end
        ST_MAKEUP: begin
          g2_q    <= g2_next;
          state_q <= ST_WET;
        end
        ST_WET: begin
          wet_l_q <= wet_l_next;
          wet_r_q <= wet_r_next;
          state_q <= ST_MIX_A;
        end
        ST_MIX_A: begin
          macc_l_q <= 50'(signed'(64'(17'h10000 - dw)) * 64'(item_q.dry_left));
          macc_r_q <= 50'(signed'(64'(17'h10000 - dw)) * 64'(item_q.dry_right));
          state_q  <= ST_MIX_B;
        end
        ST_MIX_B: begin
          mr_l_q  <= 34'(spcm_pkg::rnd_shift(64'(macc_l_q)
                     + signed'(64'(dw)) * (64'(wet_l_q) <<< 3), 16));
          mr_r_q  <= 34'(spcm_pkg::rnd_shift(64'(macc_r_q)
                     + signed'(64'(dw)) * (64'(wet_r_q) <<< 3), 16));
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_left_q  <= (o_l > SatHi) ? 24'sh7FFFFF :
                           (o_l < SatLo) ? 24'sh800000 : 24'(o_l);
            out_right_q <= (o_r > SatHi) ? 24'sh7FFFFF :
                           (o_r < SatLo) ? 24'sh800000 : 24'(o_r);
            clipped_q   <= (o_l > SatHi) || (o_l < SatLo) || (o_r > SatHi) || (o_r < SatLo);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/stereo_peak_compressor_mix_tb.sv
// Self-checking testbench for the stereo peak compressor with dry/wet mix.
`timescale 1ns / 1ps
module stereo_peak_compressor_mix_tb;

  localparam int MaxCycles = 600000;
  localparam int Depth = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  spcm_pkg::sample_t wet_left_i = '0, wet_right_i = '0, dry_left_i = '0, dry_right_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  spcm_pkg::sample_t out_left_o, out_right_o;
  logic clipped_o;
  logic cfg_we_i = 1'b0;
  logic [spcm_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [spcm_pkg::CfgDataBits-1:0] cfg_wdata_i = '0;

  typedef struct packed {
    spcm_pkg::sample_t left;
    spcm_pkg::sample_t right;
    logic              clip;
  } frame_out_t;

  frame_out_t expected_q[$];
  logic [63:0] log_lut[Depth+1];
  logic [63:0] exp_lut[Depth+1];
  logic [63:0] env;
  logic        m_enable;
  logic [63:0] m_slope, m_makeup, m_attack, m_release, m_mix, m_outgain;
  int          send_idle, recv_idle;
  bit          hold_off;
  int          errors, cycles;

  always #2 clk_i = ~clk_i;

  stereo_peak_compressor_mix u_top (.*);

  function automatic logic [63:0] frac_log2(input logic [63:0] w_in);
    logic [63:0] w;
    logic [63:0] r;
    w = w_in;
    r = 0;
    for (int k = 0; k < 16; k++) begin
      w = (w * w) >> 30;
      r = r << 1;
      if (w >= 64'h8000_0000) begin
        w = w >> 1;
        r = r | 1;
      end
    end
    return r;
  endfunction

  task automatic fill_luts();
    logic [63:0] lo, hi, mid, tgt;
    for (int i = 0; i < Depth; i++)
      log_lut[i] = frac_log2(64'h4000_0000 + ((64'(i) << 30) + Depth / 2) / Depth);
    log_lut[Depth] = 65536;
    exp_lut[0] = 65536;
    for (int i = 1; i < Depth; i++) begin
      tgt = ((64'(i) << 16) + Depth / 2) / Depth;
      lo = 64'h4000_0000;
      hi = 64'h7FFF_FFFF;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (frac_log2(mid) >= tgt) hi = mid;
        else lo = mid + 1;
      end
      exp_lut[i] = ((64'd1 << 46) + lo / 2) / lo;
    end
    exp_lut[Depth] = 32768;
  endtask

  function automatic logic [63:0] lut_lookup(input bit use_exp, input logic [63:0] f);
    logic [63:0] t, i, r, a, b;
    t = f * Depth;
    i = t >> 16;
    r = t & 64'hFFFF;
    if (i >= Depth) i = Depth - 1;
    a = use_exp ? exp_lut[i] : log_lut[i];
    b = use_exp ? exp_lut[i+1] : log_lut[i+1];
    if (b >= a) return a + (((b - a) * r) >> 16);
    return a - (((a - b) * r) >> 16);
  endfunction

  function automatic logic [63:0] comp_gain(input logic [63:0] e);
    int p;
    logic [63:0] f, l, s, k, g;
    if (e <= (64'd1 << 18)) return 65536;
    p = 0;
    while ((e >> (p + 1)) != 0) p++;
    f = (p >= 16) ? ((e >> (p - 16)) & 64'hFFFF) : ((e << (16 - p)) & 64'hFFFF);
    l = (64'(p - 18) << 16) + lut_lookup(1'b0, f);
    s = (m_slope * l) >> 16;
    k = s >> 16;
    g = lut_lookup(1'b1, s & 64'hFFFF);
    return (k < 32) ? (g >> k) : 0;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m > 8388607) ? 8388607 : m;
  endfunction

  task automatic predict_frame(input spcm_pkg::sample_t wl, wr, dl, dr);
    longint wet[2], dry[2], m, o;
    logic [63:0] pk, c, g2;
    longint dw;
    frame_out_t res;
    wet[0] = wl;
    wet[1] = wr;
    dry[0] = dl;
    dry[1] = dr;
    dw = (m_mix > 65536) ? 65536 : m_mix;
    res = '0;
    if (m_enable) begin
      pk = magnitude(wet[0]);
      if (magnitude(wet[1]) > pk) pk = magnitude(wet[1]);
      c = (pk > env) ? m_attack : m_release;
      env = (c * env + (65536 - c) * pk + 32768) >> 16;
      g2 = (comp_gain(env) * m_makeup + 2048) >> 12;
      wet[0] = round_shift(wet[0] * longint'(g2), 16);
      wet[1] = round_shift(wet[1] * longint'(g2), 16);
    end
    for (int ch = 0; ch < 2; ch++) begin
      m = (65536 - dw) * dry[ch] + dw * (wet[ch] * 8);
      o = round_shift(round_shift(m, 16) * longint'(m_outgain), 12);
      if (o > 8388607) begin
        o = 8388607;
        res.clip = 1'b1;
      end
      if (o < -8388608) begin
        o = -8388608;
        res.clip = 1'b1;
      end
      if (ch == 0) res.left = spcm_pkg::sample_t'(o);
      else res.right = spcm_pkg::sample_t'(o);
    end
    expected_q = {expected_q, res};
  endtask

  task automatic send_frame(input spcm_pkg::sample_t wl, wr, dl, dr);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    wet_left_i <= wl;
    wet_right_i <= wr;
    dry_left_i <= dl;
    dry_right_i <= dr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame(wl, wr, dl, dr);
  endtask

  function automatic spcm_pkg::sample_t rand_sample();
    case ($urandom_range(5))
      0: return spcm_pkg::sample_t'(24'h800000);
      1: return spcm_pkg::sample_t'(24'h7FFFFF);
      2: return spcm_pkg::sample_t'($urandom_range(2047) - 1024);
      default: return spcm_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input spcm_pkg::reg_idx_e idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= spcm_pkg::CfgDataBits'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      spcm_pkg::REG_COMP_ENABLE: m_enable = val[0];
      spcm_pkg::REG_COMP_SLOPE: m_slope = val & 64'hFFFF;
      spcm_pkg::REG_MAKEUP_GAIN: m_makeup = val & 64'h3FFF;
      spcm_pkg::REG_ATTACK_COEFF: m_attack = val & 64'hFFFF;
      spcm_pkg::REG_RELEASE_COEFF: m_release = val & 64'hFFFF;
      spcm_pkg::REG_DRY_WET: m_mix = val & 64'h1FFFF;
      spcm_pkg::REG_OUTPUT_GAIN: m_outgain = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic random_settings();
    write_reg(spcm_pkg::REG_COMP_ENABLE, $urandom_range(3) != 0);
    write_reg(spcm_pkg::REG_COMP_SLOPE,
              $urandom_range(1) ? $urandom_range(62259) : $urandom_range(65535));
    write_reg(spcm_pkg::REG_MAKEUP_GAIN, $urandom_range(4) ? $urandom_range(12953, 4096)
                                                           : $urandom_range(16383));
    write_reg(spcm_pkg::REG_ATTACK_COEFF, $urandom_range(65535));
    write_reg(spcm_pkg::REG_RELEASE_COEFF, $urandom_range(65535));
    write_reg(spcm_pkg::REG_DRY_WET,
              $urandom_range(3) ? $urandom_range(65536) : $urandom_range(131071));
    write_reg(spcm_pkg::REG_OUTPUT_GAIN, $urandom_range(64924, 4096));
  endtask

  task automatic test_directed();
    spcm_pkg::sample_t edge_vals[4];
    edge_vals = '{spcm_pkg::sample_t'(24'h800000), spcm_pkg::sample_t'(24'h7FFFFF), '0,
                  spcm_pkg::sample_t'(-1)};
    for (int i = 0; i < 4; i++) send_frame(edge_vals[i], edge_vals[3-i], edge_vals[i],
                                           edge_vals[(i+1)%4]);
    drain();
    write_reg(spcm_pkg::REG_COMP_ENABLE, 1);
    write_reg(spcm_pkg::REG_COMP_SLOPE, 62259);
    write_reg(spcm_pkg::REG_MAKEUP_GAIN, 12953);
    write_reg(spcm_pkg::REG_ATTACK_COEFF, 0);
    write_reg(spcm_pkg::REG_RELEASE_COEFF, 65535);
    write_reg(spcm_pkg::REG_DRY_WET, 131071);
    write_reg(spcm_pkg::REG_OUTPUT_GAIN, 64924);
    for (int i = 0; i < 8; i++) send_frame(edge_vals[i%4], edge_vals[(i+1)%4],
                                           edge_vals[(i+2)%4], edge_vals[i%4]);
    drain();
    write_reg(spcm_pkg::REG_DRY_WET, 0);
    write_reg(spcm_pkg::REG_OUTPUT_GAIN, 4096);
    write_reg(spcm_pkg::REG_MAKEUP_GAIN, 16383);
    write_reg(spcm_pkg::REG_COMP_SLOPE, 65535);
    for (int i = 0; i < 6; i++) send_frame(edge_vals[i%4], edge_vals[1], edge_vals[0],
                                           edge_vals[1]);
    drain();
    write_reg(spcm_pkg::REG_COMP_ENABLE, 0);
    for (int i = 0; i < 3; i++) send_frame(edge_vals[1], edge_vals[0], edge_vals[1],
                                           edge_vals[0]);
    drain();
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int count);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        drain();
        random_settings();
      end
      send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_off = 1'b1;
    for (int n = 0; n < 30; n++)
      send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      repeat (300) @(posedge clk_i);
      hold_off <= 1'b0;
    end else begin
      out_stall_i <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    frame_out_t exp_f;
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %0d %0d", out_left_o, out_right_o);
      end else begin
        exp_f = expected_q.pop_front();
        if (exp_f.left !== out_left_o || exp_f.right !== out_right_o
            || exp_f.clip !== clipped_o) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp %0d %0d %0b got %0d %0d %0b", exp_f.left, exp_f.right,
                     exp_f.clip, out_left_o, out_right_o, clipped_o);
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    env = 0;
    m_enable = 0;
    m_slope = 0;
    m_makeup = 4096;
    m_attack = 65263;
    m_release = 65522;
    m_mix = 65536;
    m_outgain = 4096;
    fill_luts();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(21, 60, 600);
    test_random(60, 21, 600);
    test_random(0, 0, 600);
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
